### sv/clbs_pkg.sv
`timescale 1ns / 1ps
package clbs_pkg;

  // Request codes on the cmd field.
  localparam logic [2:0] CMD_TICK   = 3'd0;
  localparam logic [2:0] CMD_INSTR  = 3'd1;
  localparam logic [2:0] CMD_DATA   = 3'd2;
  localparam logic [2:0] CMD_INIT   = 3'd3;
  localparam logic [2:0] CMD_CURSOR = 3'd4;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_POWER_UP  = 3'd0;
  localparam logic [2:0] REG_FIRST_WT  = 3'd1;
  localparam logic [2:0] REG_SECOND_WT = 3'd2;
  localparam logic [2:0] REG_SETTLE    = 3'd3;
  localparam logic [2:0] REG_PULSE     = 3'd4;

  localparam logic [15:0] RST_POWER_UP  = 16'd40000;
  localparam logic [15:0] RST_FIRST_WT  = 16'd4100;
  localparam logic [15:0] RST_SECOND_WT = 16'd100;
  localparam logic [15:0] RST_SETTLE    = 16'd100;
  localparam logic [7:0]  RST_PULSE     = 8'd1;

  localparam logic [7:0] CURSOR_BASE = 8'h80;
  localparam logic [3:0] INIT_STEPS  = 4'd8;

  typedef enum logic [2:0] {
    K_NONE,
    K_INSTR,
    K_DATA,
    K_INIT,
    K_CURSOR
  } kind_e;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_POWER,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_SETTLE,
    PH_EXTRA,
    PH_POLL_HIGH,
    PH_POLL_LOW,
    PH_POLL_END
  } phase_e;

  // One classified request as it waits in the queue.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] wr_byte;
    logic       busy;
  } item_t;

  typedef struct packed {
    logic [15:0] power_up;
    logic [15:0] first_wt;
    logic [15:0] second_wt;
    logic [15:0] settle;
    logic [7:0]  pulse;
  } cfg_t;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [7:0] bus;
    logic       drive;
  } pins_t;

  // Power-up sequence bytes, indexed by step minus one.
  function automatic logic [7:0] init_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'h30;
      3'd1:    b = 8'h30;
      3'd2:    b = 8'h30;
      3'd3:    b = 8'h38;
      3'd4:    b = 8'h08;
      3'd5:    b = 8'h01;
      3'd6:    b = 8'h06;
      3'd7:    b = 8'h0E;
      default: b = 8'h30;
    endcase
    return b;
  endfunction

endpackage

### sv/clbs_if.sv
`timescale 1ns / 1ps
interface clbs_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] data_byte;
  logic       cursor_row;
  logic [5:0] cursor_col;
  logic       busy_in;

  modport source (output valid, cmd, data_byte, cursor_row, cursor_col, busy_in,
                  input ready);
  modport sink (input valid, cmd, data_byte, cursor_row, cursor_col, busy_in,
                output ready);
endinterface

interface clbs_res_if;
  logic       valid;
  logic       ready;
  logic       rs_level;
  logic       rw_level;
  logic       en_level;
  logic [7:0] bus_out;
  logic       bus_drive;
  logic       ready_res;
  logic       rejected;

  modport source (output valid, rs_level, rw_level, en_level, bus_out, bus_drive,
                  ready_res, rejected, input ready);
  modport sink (input valid, rs_level, rw_level, en_level, bus_out, bus_drive,
                ready_res, rejected, output ready);
endinterface

### sv/clbs_front.sv
`timescale 1ns / 1ps
module clbs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  clbs_req_if.sink       req_i,
  output logic           q_valid_o,
  output clbs_pkg::item_t q_item_o,
  input  logic           q_pop_i
);
  import clbs_pkg::*;

  item_t      item_c;
  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  // Decode the command and form the byte to be written.
  always_comb begin
    item_c.busy    = req_i.busy_in;
    item_c.wr_byte = req_i.data_byte;
    case (req_i.cmd)
      CMD_INSTR:  item_c.kind = K_INSTR;
      CMD_DATA:   item_c.kind = K_DATA;
      CMD_INIT:   item_c.kind = K_INIT;
      CMD_CURSOR: begin
        item_c.kind    = K_CURSOR;
        item_c.wr_byte = CURSOR_BASE | {1'b0, req_i.cursor_row, req_i.cursor_col};
      end
      default:    item_c.kind = K_NONE;
    endcase
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_item_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = q_pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_c;
    end
  end

endmodule

### sv/clbs_back.sv
`timescale 1ns / 1ps
module clbs_back #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  clbs_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  input  clbs_pkg::item_t q_item_i,
  output logic            q_pop_o,
  clbs_res_if.source      res_o
);
  import clbs_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  phase_e                 phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;
  logic [3:0]             step_q, step_d;
  logic [7:0]             pbyte_q, pbyte_d;
  logic                   prs_q, prs_d;
  logic                   ppoll_q, ppoll_d;
  pins_t                  pins_q, pins_d;
  logic                   rej_d;
  logic                   out_valid_q;
  pins_t                  out_pins_q;
  logic                   out_rdy_q;
  logic                   out_rej_q;
  logic                   adv;

  // A loaded value saturates at the largest counter value.
  function automatic logic [COUNT_WIDTH-1:0] load_cnt(input logic [15:0] v);
    logic [31:0] v32;
    logic [31:0] lim;
    v32 = 32'(v);
    lim = 32'(CNT_MAX);
    return (v32 > lim) ? CNT_MAX : COUNT_WIDTH'(v32);
  endfunction

  assign adv     = q_valid_i && (!out_valid_q || res_o.ready);
  assign q_pop_o = adv;

  // One tick of the sequencer: request handling, then the phase work.
  always_comb begin
    logic done;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    step_d  = step_q;
    pbyte_d = pbyte_q;
    prs_d   = prs_q;
    ppoll_d = ppoll_q;
    pins_d  = pins_q;
    rej_d   = 1'b0;
    done    = 1'b0;

    if (q_item_i.kind != K_NONE) begin
      if (phase_d != PH_IDLE) begin
        rej_d = 1'b1;
      end else begin
        step_d = 4'd0;
        case (q_item_i.kind)
          K_INIT: begin
            phase_d = PH_POWER;
            cnt_d   = load_cnt(cfg_i.power_up);
          end
          default: begin
            pbyte_d = q_item_i.wr_byte;
            prs_d   = (q_item_i.kind == K_DATA);
            ppoll_d = (q_item_i.kind != K_CURSOR);
            phase_d = PH_WR_LOW;
            cnt_d   = load_cnt(16'(cfg_i.pulse));
          end
        endcase
      end
    end

    // Timed phases end when the count is at or below one.
    if (cnt_d <= COUNT_WIDTH'(1)) begin
      done = 1'b1;
    end

    case (phase_d)
      PH_IDLE: begin
      end
      PH_POWER: begin
        if (done) begin
          step_d  = 4'd1;
          pbyte_d = init_byte(3'd0);
          prs_d   = 1'b0;
          ppoll_d = 1'b1;
          phase_d = PH_WR_LOW;
          cnt_d   = load_cnt(16'(cfg_i.pulse));
        end else begin
          cnt_d = cnt_d - COUNT_WIDTH'(1);
        end
      end
      PH_WR_LOW, PH_WR_HIGH, PH_SETTLE, PH_EXTRA: begin
        pins_d.rs    = prs_d;
        pins_d.rw    = 1'b0;
        pins_d.en    = (phase_d == PH_WR_HIGH);
        pins_d.bus   = pbyte_d;
        pins_d.drive = 1'b1;
        if (!done) begin
          cnt_d = cnt_d - COUNT_WIDTH'(1);
        end else if (phase_d == PH_WR_LOW) begin
          phase_d = PH_WR_HIGH;
          cnt_d   = load_cnt(16'(cfg_i.pulse));
        end else if (phase_d == PH_WR_HIGH) begin
          phase_d = PH_SETTLE;
          cnt_d   = load_cnt(cfg_i.settle);
        end else if (phase_d == PH_SETTLE && step_d == 4'd1) begin
          phase_d = PH_EXTRA;
          cnt_d   = load_cnt(cfg_i.first_wt);
        end else if (phase_d == PH_SETTLE && step_d == 4'd2) begin
          phase_d = PH_EXTRA;
          cnt_d   = load_cnt(cfg_i.second_wt);
        end else if (phase_d == PH_SETTLE && ppoll_d) begin
          phase_d = PH_POLL_HIGH;
        end else begin
          phase_d = PH_POLL_END;
        end
      end
      PH_POLL_HIGH: begin
        pins_d  = '{rs: 1'b0, rw: 1'b1, en: 1'b1, bus: 8'h00, drive: 1'b0};
        phase_d = q_item_i.busy ? PH_POLL_LOW : PH_POLL_END;
      end
      PH_POLL_LOW: begin
        pins_d  = '{rs: 1'b0, rw: 1'b1, en: 1'b0, bus: 8'h00, drive: 1'b0};
        phase_d = PH_POLL_HIGH;
      end
      PH_POLL_END: begin
        pins_d  = '{rs: 1'b0, rw: 1'b1, en: 1'b0, bus: 8'h00, drive: 1'b0};
      end
      default: begin
        phase_d = PH_IDLE;
        step_d  = 4'd0;
      end
    endcase

    // The end of an operation: either the next init byte or back to idle.
    // A write that ends without polling reaches here through the settle
    // or extra wait, marked by the poll-end code set above. A poll-end
    // phase entered from a busy-flag read still has its own tick to run.
    if (phase_d == PH_POLL_END && phase_q != PH_POLL_HIGH) begin
      if (step_d >= 4'd1 && step_d < INIT_STEPS) begin
        pbyte_d = init_byte(step_d[2:0]);
        step_d  = step_d + 4'd1;
        prs_d   = 1'b0;
        ppoll_d = 1'b1;
        phase_d = PH_WR_LOW;
        cnt_d   = load_cnt(16'(cfg_i.pulse));
      end else begin
        step_d  = 4'd0;
        phase_d = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      step_q      <= 4'd0;
      pbyte_q     <= 8'h00;
      prs_q       <= 1'b0;
      ppoll_q     <= 1'b0;
      pins_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        step_q  <= step_d;
        pbyte_q <= pbyte_d;
        prs_q   <= prs_d;
        ppoll_q <= ppoll_d;
        pins_q  <= pins_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pins_q <= pins_d;
      out_rdy_q  <= (phase_d == PH_IDLE);
      out_rej_q  <= rej_d;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.rs_level  = out_pins_q.rs;
  assign res_o.rw_level  = out_pins_q.rw;
  assign res_o.en_level  = out_pins_q.en;
  assign res_o.bus_out   = out_pins_q.bus;
  assign res_o.bus_drive = out_pins_q.drive;
  assign res_o.ready_res = out_rdy_q;
  assign res_o.rejected  = out_rej_q;

endmodule

### sv/char_lcd_bus_sequencer_core.sv
`timescale 1ns / 1ps
// Channel   Modport  Moves                                   Accepted when
// req_i     sink     one tick request: cmd, byte, cursor,    valid && ready
//                    busy_in
// res_o     source   line levels, ready_res, rejected        valid && ready
// apb       slave    five timing registers at 4*index        psel && penable && pwrite
//
// Every request gives exactly one result, one request per clock sustained
// while results are taken. A request passes first through the two-entry
// queue, then through the sequencer step, whose result lands in the output
// register. Reset clears the queue, the sequencer and the output register
// at once. A stalled result holds the sequencer; the queue keeps taking
// requests until both of its entries are full.
module char_lcd_bus_sequencer_core #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clbs_req_if.sink    req_i,
  clbs_res_if.source  res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import clbs_pkg::*;

  // Timing registers, read directly by the sequencer. The user must make writes
  // only while no request is in flight; the block itself does not enforce it.
  cfg_t       cfg_q;
  logic       cfg_we;
  logic [2:0] reg_idx;

  logic       q_valid;
  item_t      q_item;
  logic       q_pop;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_up  <= RST_POWER_UP;
      cfg_q.first_wt  <= RST_FIRST_WT;
      cfg_q.second_wt <= RST_SECOND_WT;
      cfg_q.settle    <= RST_SETTLE;
      cfg_q.pulse     <= RST_PULSE;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_POWER_UP:  cfg_q.power_up  <= pwdata[15:0];
        REG_FIRST_WT:  cfg_q.first_wt  <= pwdata[15:0];
        REG_SECOND_WT: cfg_q.second_wt <= pwdata[15:0];
        REG_SETTLE:    cfg_q.settle    <= pwdata[15:0];
        REG_PULSE:     cfg_q.pulse     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read data is combinational off the register index.
  always_comb begin
    case (reg_idx)
      REG_POWER_UP:  prdata = 32'(cfg_q.power_up);
      REG_FIRST_WT:  prdata = 32'(cfg_q.first_wt);
      REG_SECOND_WT: prdata = 32'(cfg_q.second_wt);
      REG_SETTLE:    prdata = 32'(cfg_q.settle);
      REG_PULSE:     prdata = 32'(cfg_q.pulse);
      default:       prdata = 32'h0;
    endcase
  end

  // Front end: decodes each request and queues it.
  clbs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  // Back end: runs one bus tick per queued request and registers the result.
  clbs_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

### sv/clbs_checker.sv
`timescale 1ns / 1ps
module clbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        res_valid,
  input logic        res_ready,
  input logic        rs_level,
  input logic        rw_level,
  input logic        en_level,
  input logic [7:0]  bus_out,
  input logic        bus_drive,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  // A released bus always reads as zero.
  a_bus_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !bus_drive |-> bus_out == 8'h00)
    else $error("bus_out nonzero while bus is released");

  // A busy-flag read never drives the bus and always selects instructions.
  a_poll_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && rw_level |-> !bus_drive && !rs_level)
    else $error("read cycle with bus driven or data register selected");

  // A stalled result holds its enable level and bus value.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(en_level) && $stable(bus_out))
    else $error("stalled result changed");

  // A write to the power-up register reads back on the next cycle.
  a_cfg_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && paddr == 5'd0 |=> prdata[15:0] == $past(pwdata[15:0]))
    else $error("power-up register read back mismatch");

endmodule

bind char_lcd_bus_sequencer_core clbs_checker u_clbs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .res_valid (res_o.valid),
  .res_ready (res_o.ready),
  .rs_level  (res_o.rs_level),
  .rw_level  (res_o.rw_level),
  .en_level  (res_o.en_level),
  .bus_out   (res_o.bus_out),
  .bus_drive (res_o.bus_drive),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

### bench/tb_char_lcd_bus_sequencer_core.sv
`timescale 1ns / 1ps
// Self-checking bench for the character LCD bus sequencer core.
//
// Every accepted request is one microsecond tick of the sequencer, and it
// produces exactly one result: the line levels for that tick, the idle flag
// and the rejected flag. A local model of the sequencer runs on each
// accepted request and queues the line levels it expects. The result
// monitor compares every accepted result with the oldest of them.
module tb_char_lcd_bus_sequencer_core;
  import clbs_pkg::*;

  // The directed part takes under a thousand ticks and the random part
  // about a thousand requests. Even with the receiver stalling in most
  // cycles the whole run stays well below the limit, which leaves a wide
  // margin.
  localparam int unsigned CYCLE_LIMIT   = 100_000;
  localparam int unsigned RANDOM_ITEMS  = 960;
  localparam int unsigned RANDOM_PHASES = 8;

  // Codes above the cursor move are not requests; the block treats them as
  // plain ticks.
  localparam logic [2:0] CMD_SPARE_A = CMD_CURSOR + 3'd1;
  localparam logic [2:0] CMD_SPARE_B = CMD_CURSOR + 3'd2;
  localparam logic [2:0] CMD_SPARE_C = CMD_CURSOR + 3'd3;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       row;
    logic [5:0] col;
    logic       busy;
  } lcd_req_t;

  typedef struct packed {
    logic       rs;
    logic       rw;
    logic       en;
    logic [7:0] bus;
    logic       drive;
    logic       idle;
    logic       rejected;
  } lcd_lines_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  clbs_req_if req_ch ();
  clbs_res_if res_ch ();

  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  char_lcd_bus_sequencer_core i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Requests waiting for the driver, and line levels waiting for results.
  lcd_req_t   lcd_requests[$];
  lcd_lines_t expected_lines[$];

  int unsigned n_issued;
  int unsigned n_accepted;
  int unsigned n_errors;
  int unsigned n_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Sequencer model state. seq_cfg mirrors the timing registers as the
  // bench last wrote them.
  phase_e      seq_phase;
  logic [15:0] seq_count;
  int unsigned seq_step;
  logic [7:0]  seq_byte;
  logic        seq_rs;
  logic        seq_poll;
  pins_t       seq_lines;
  cfg_t        seq_cfg;

  // Bytes of the power-up sequence; step counts from one.
  function automatic logic [7:0] power_on_byte(int unsigned step);
    case (step)
      4:       return 8'h38;
      5:       return 8'h08;
      6:       return 8'h01;
      7:       return 8'h06;
      8:       return 8'h0E;
      default: return 8'h30;
    endcase
  endfunction

  function automatic void set_lines(logic rs, logic rw, logic en, logic [7:0] b,
                                    logic drive);
    seq_lines.rs    = rs;
    seq_lines.rw    = rw;
    seq_lines.en    = en;
    seq_lines.bus   = drive ? b : 8'h00;
    seq_lines.drive = drive;
  endfunction

  function automatic void begin_write(logic [7:0] b, logic rs, logic poll);
    seq_byte  = b;
    seq_rs    = rs;
    seq_poll  = poll;
    seq_phase = PH_WR_LOW;
    seq_count = 16'(seq_cfg.pulse);
  endfunction

  // A timed phase ends on the tick that finds its count at one or zero, so
  // a count of zero still lasts one tick.
  function automatic bit count_expired();
    if (seq_count <= 16'd1) return 1'b1;
    seq_count = seq_count - 16'd1;
    return 1'b0;
  endfunction

  // Either go on to the next byte of the init sequence or fall back to idle.
  function automatic void end_operation();
    if (seq_step >= 1 && seq_step < INIT_STEPS) begin
      seq_step++;
      begin_write(power_on_byte(seq_step), 1'b0, 1'b1);
    end else begin
      seq_step  = 0;
      seq_phase = PH_IDLE;
    end
  endfunction

  function automatic void advance_tick(logic busy);
    case (seq_phase)
      PH_POWER: begin
        if (count_expired()) begin
          seq_step = 1;
          begin_write(power_on_byte(1), 1'b0, 1'b1);
        end
      end
      PH_WR_LOW: begin
        set_lines(seq_rs, 1'b0, 1'b0, seq_byte, 1'b1);
        if (count_expired()) begin
          seq_phase = PH_WR_HIGH;
          seq_count = 16'(seq_cfg.pulse);
        end
      end
      PH_WR_HIGH: begin
        set_lines(seq_rs, 1'b0, 1'b1, seq_byte, 1'b1);
        if (count_expired()) begin
          seq_phase = PH_SETTLE;
          seq_count = seq_cfg.settle;
        end
      end
      PH_SETTLE: begin
        set_lines(seq_rs, 1'b0, 1'b0, seq_byte, 1'b1);
        if (count_expired()) begin
          // The first two function sets wait fixed times instead of polling.
          if (seq_step == 1) begin
            seq_phase = PH_EXTRA;
            seq_count = seq_cfg.first_wt;
          end else if (seq_step == 2) begin
            seq_phase = PH_EXTRA;
            seq_count = seq_cfg.second_wt;
          end else if (seq_poll) begin
            seq_phase = PH_POLL_HIGH;
          end else begin
            end_operation();
          end
        end
      end
      PH_EXTRA: begin
        set_lines(seq_rs, 1'b0, 1'b0, seq_byte, 1'b1);
        if (count_expired()) end_operation();
      end
      PH_POLL_HIGH: begin
        // Busy flag is sampled on the tick with EN high and the bus released.
        set_lines(1'b0, 1'b1, 1'b1, 8'h00, 1'b0);
        seq_phase = busy ? PH_POLL_LOW : PH_POLL_END;
      end
      PH_POLL_LOW: begin
        set_lines(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        seq_phase = PH_POLL_HIGH;
      end
      PH_POLL_END: begin
        set_lines(1'b0, 1'b1, 1'b0, 8'h00, 1'b0);
        end_operation();
      end
      default: begin
        seq_phase = PH_IDLE;
        seq_step  = 0;
      end
    endcase
  endfunction

  // One tick of the model: start the request if the sequencer is idle,
  // refuse it otherwise, then run the current phase.
  function automatic lcd_lines_t predict_lines(lcd_req_t r);
    lcd_lines_t o;
    logic       refused;
    refused = 1'b0;
    if (r.cmd inside {CMD_INSTR, CMD_DATA, CMD_INIT, CMD_CURSOR}) begin
      if (seq_phase != PH_IDLE) begin
        refused = 1'b1;
      end else begin
        seq_step = 0;
        case (r.cmd)
          CMD_INSTR: begin_write(r.data_byte, 1'b0, 1'b1);
          CMD_DATA:  begin_write(r.data_byte, 1'b1, 1'b1);
          CMD_INIT: begin
            seq_phase = PH_POWER;
            seq_count = seq_cfg.power_up;
          end
          default:   begin_write(CURSOR_BASE | {1'b0, r.row, r.col}, 1'b0, 1'b0);
        endcase
      end
    end
    if (seq_phase != PH_IDLE) advance_tick(r.busy);
    o.rs       = seq_lines.rs;
    o.rw       = seq_lines.rw;
    o.en       = seq_lines.en;
    o.bus      = seq_lines.bus;
    o.drive    = seq_lines.drive;
    o.idle     = (seq_phase == PH_IDLE);
    o.rejected = refused;
    return o;
  endfunction

  function automatic void queue_request(logic [2:0] cmd, logic [7:0] b, logic row,
                                        logic [5:0] col, logic busy);
    lcd_req_t r;
    r.cmd       = cmd;
    r.data_byte = b;
    r.row       = row;
    r.col       = col;
    r.busy      = busy;
    lcd_requests.push_back(r);
    n_issued++;
  endfunction

  // Mostly plain ticks, so that accepted requests run to completion and the
  // busy polling gets exercised; the real requests among the rest are refused
  // whenever they land on a busy sequencer.
  function automatic void queue_random();
    int unsigned pick;
    logic [2:0]  cmd;
    pick = $urandom_range(99);
    if (pick < 74)      cmd = CMD_TICK;
    else if (pick < 78) cmd = CMD_SPARE_A + 3'($urandom_range(2));
    else if (pick < 86) cmd = CMD_INSTR;
    else if (pick < 94) cmd = CMD_DATA;
    else if (pick < 98) cmd = CMD_CURSOR;
    else                cmd = CMD_INIT;
    queue_request(cmd, 8'($urandom()), 1'($urandom()), 6'($urandom()),
                  $urandom_range(99) < 40);
  endfunction

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      n_errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // A register write has a setup phase and then an access phase; it lands at
  // the edge that ends the access phase.
  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_timing(cfg_t c);
    apb_write(REG_POWER_UP,  {16'd0, c.power_up});
    apb_write(REG_FIRST_WT,  {16'd0, c.first_wt});
    apb_write(REG_SECOND_WT, {16'd0, c.second_wt});
    apb_write(REG_SETTLE,    {16'd0, c.settle});
    apb_write(REG_PULSE,     {24'd0, c.pulse});
    seq_cfg = c;
  endtask

  // Checked at the falling edge so the counters are never read half updated.
  task automatic wait_delivered();
    do @(negedge clk_i);
    while (n_accepted != n_issued || expected_lines.size() != 0);
  endtask

  // Results all being back does not mean the sequencer is idle: an init or
  // a long settle may still be running. Feed quiet ticks until the model
  // says idle, so that a register write never lands mid-operation.
  task automatic run_to_idle();
    wait_delivered();
    while (seq_phase != PH_IDLE) begin
      repeat (int'(seq_count) + 16) queue_request(CMD_TICK, 8'h00, 1'b0, 6'd0, 1'b0);
      wait_delivered();
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Request driver. A new request goes out only once the current one has
  // been taken, and the sender idles at the rate of the current phase.
  always @(posedge clk_i or negedge rst_ni) begin : request_driver
    lcd_req_t head;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_ch.ready) begin
      if (lcd_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        head = lcd_requests.pop_front();
        req_ch.valid      <= 1'b1;
        req_ch.cmd        <= head.cmd;
        req_ch.data_byte  <= head.data_byte;
        req_ch.cursor_row <= head.row;
        req_ch.cursor_col <= head.col;
        req_ch.busy_in    <= head.busy;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: models each accepted request and checks each accepted result.
  // The timeout check stays last so nothing runs after its finish.
  always @(posedge clk_i) begin : line_monitor
    lcd_req_t   seen;
    lcd_lines_t want;
    if (rst_ni) begin
      n_cycles++;
      if (req_ch.valid && req_ch.ready) begin
        seen.cmd       = req_ch.cmd;
        seen.data_byte = req_ch.data_byte;
        seen.row       = req_ch.cursor_row;
        seen.col       = req_ch.cursor_col;
        seen.busy      = req_ch.busy_in;
        expected_lines.push_back(predict_lines(seen));
        n_accepted++;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_lines.size() == 0) begin
          n_errors++;
          $display("%0t: result with nothing expected, actual rs %b rw %b en %b bus 0x%0h",
                   $time, res_ch.rs_level, res_ch.rw_level, res_ch.en_level,
                   res_ch.bus_out);
        end else begin
          want = expected_lines.pop_front();
          compare_field("rs_level",  want.rs,       res_ch.rs_level);
          compare_field("rw_level",  want.rw,       res_ch.rw_level);
          compare_field("en_level",  want.en,       res_ch.en_level);
          compare_field("bus_out",   want.bus,      res_ch.bus_out);
          compare_field("bus_drive", want.drive,    res_ch.bus_drive);
          compare_field("ready_res", want.idle,     res_ch.ready_res);
          compare_field("rejected",  want.rejected, res_ch.rejected);
        end
      end
      if (n_cycles > CYCLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    cfg_t c;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_TICK;
    req_ch.data_byte  = 8'h00;
    req_ch.cursor_row = 1'b0;
    req_ch.cursor_col = 6'd0;
    req_ch.busy_in    = 1'b0;
    res_ch.ready      = 1'b1;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    n_issued          = 0;
    n_accepted        = 0;
    n_errors          = 0;
    n_cycles          = 0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    seq_phase         = PH_IDLE;
    seq_count         = '0;
    seq_step          = 0;
    seq_byte          = '0;
    seq_rs            = 1'b0;
    seq_poll          = 1'b0;
    seq_lines         = '0;
    seq_cfg           = '{RST_POWER_UP, RST_FIRST_WT, RST_SECOND_WT, RST_SETTLE, RST_PULSE};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset timing, no idling. An instruction write with all ones, then
    // requests of every other kind while it runs, which must all be refused, and
    // the spare codes, which act as ticks.
    queue_request(CMD_INSTR,   8'hFF, 1'b0, 6'd0,  1'b0);
    queue_request(CMD_DATA,    8'h00, 1'b0, 6'd0,  1'b0);
    queue_request(CMD_INIT,    8'h00, 1'b0, 6'd0,  1'b1);
    queue_request(CMD_CURSOR,  8'h00, 1'b1, 6'd63, 1'b1);
    queue_request(CMD_SPARE_A, 8'hFF, 1'b1, 6'd63, 1'b1);
    queue_request(CMD_SPARE_B, 8'h00, 1'b0, 6'd0,  1'b1);
    queue_request(CMD_SPARE_C, 8'hFF, 1'b1, 6'd63, 1'b1);
    run_to_idle();
    // Full power-up sequence with short waits of distinct lengths.
    write_timing('{16'd20, 16'd12, 16'd5, 16'd3, 8'd2});
    queue_request(CMD_INIT, 8'h00, 1'b0, 6'd0, 1'b0);
    run_to_idle();

    // All counts at zero or one, so every timed phase is a single tick.
    // The instruction write meets a busy display for two polls.
    write_timing('{16'd0, 16'd0, 16'd0, 16'd0, 8'd1});
    queue_request(CMD_INSTR, 8'h00, 1'b0, 6'd0, 1'b0);
    repeat (5) queue_request(CMD_TICK, 8'h00, 1'b0, 6'd0, 1'b1);
    repeat (2) queue_request(CMD_TICK, 8'h00, 1'b0, 6'd0, 1'b0);
    run_to_idle();
    queue_request(CMD_DATA, 8'hFF, 1'b0, 6'd0, 1'b0);
    run_to_idle();
    queue_request(CMD_CURSOR, 8'hFF, 1'b0, 6'd0, 1'b0);
    run_to_idle();
    queue_request(CMD_INIT, 8'h00, 1'b0, 6'd0, 1'b0);
    run_to_idle();

    // Longest enable pulse on a cursor move.
    write_timing('{16'd0, 16'd0, 16'd0, 16'd0, 8'hFF});
    queue_request(CMD_CURSOR, 8'h00, 1'b1, 6'h2A, 1'b0);
    run_to_idle();

    // Random traffic with short timing so that many operations complete.
    // Each phase picks new timing and one of the idling patterns.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      c.power_up  = 16'($urandom_range(6));
      c.first_wt  = 16'($urandom_range(6));
      c.second_wt = 16'($urandom_range(6));
      c.settle    = 16'($urandom_range(6));
      c.pulse     = 8'($urandom_range(3, 1));
      write_timing(c);
      repeat (RANDOM_ITEMS / RANDOM_PHASES) queue_random();
      run_to_idle();
    end

    if (n_errors == 0 && expected_lines.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
